/* src/prkm_pkg.sv */
// Package: keyword ROM, field widths and shared types for the keyword matcher
`default_nettype none
package prkm_pkg;

    localparam int NumKeywordsDefault  = 160;
    localparam int MaxKeywordLenDefault = 24;
    localparam int ChunkBytesDefault   = 262144;
    localparam int RomWords            = 145;
    localparam int SlotChars           = 24;

    localparam logic [7:0] TextLo = 8'h20;
    localparam logic [7:0] TextHi = 8'h7E;

    localparam logic [4:0] MinRunReset = 5'd5;
    localparam logic [7:0] MaxDetReset = 8'd8;

    // register indexes on the configuration port
    localparam logic [0:0] RegMinRun = 1'b0;
    localparam logic [0:0] RegMaxDet = 1'b1;

    typedef struct packed {
        logic [SlotChars*8-1:0] text;   // character 0 in bits [7:0]
        logic [4:0]             len;
        logic [3:0]             cat;
        logic                   crit;
    } rom_word_t;

    // a space in the keyword text stands for an underscore
    function automatic rom_word_t mk(input string s, input int c, input int k);
        rom_word_t w;
        w.text = '0;
        for (int i = 0; i < SlotChars; i++)
        begin
            if (i < s.len())
            begin
                if (s[i] == " ")
                begin
                    w.text[i*8 +: 8] = "_";
                end
                else
                begin
                    w.text[i*8 +: 8] = s[i];
                end
            end
        end
        w.len  = 5'(s.len());
        w.cat  = 4'(c);
        w.crit = 1'(k);
        return w;
    endfunction

    function automatic rom_word_t word_rom(input int idx);
        rom_word_t w;
        w = '0;
        case (idx)
            0: w = mk("aimbot",0,1);          1: w = mk("aim bot",0,1);
            2: w = mk("silentaim",0,1);       3: w = mk("silent aim",0,1);
            4: w = mk("triggerbot",0,1);      5: w = mk("trigger bot",0,1);
            6: w = mk("fovcheat",0,1);        7: w = mk("aimassist",0,0);
            8: w = mk("aimkey",0,0);
            9: w = mk("esp draw",1,1);        10: w = mk("wallhack",1,1);
            11: w = mk("wall hack",1,1);      12: w = mk("boneesp",1,1);
            13: w = mk("playeresp",1,1);      14: w = mk("esp box",1,1);
            15: w = mk("espcolor",1,0);       16: w = mk("chams",1,0);
            17: w = mk("glowhack",1,0);
            18: w = mk("redenginelib",2,1);   19: w = mk("red-engine",2,1);
            20: w = mk("redengine",2,1);      21: w = mk("flkbypass",2,1);
            22: w = mk("flk bypass",2,1);     23: w = mk("anti-echo",2,1);
            24: w = mk("antiecho",2,1);       25: w = mk("headshot.dll",2,1);
            26: w = mk("tzxcheat",2,1);       27: w = mk("quantaclient",2,1);
            28: w = mk("quanta client",2,1);  29: w = mk("doomsdaycheat",2,1);
            30: w = mk("doomsday cheat",2,1); 31: w = mk("crusadercheat",2,1);
            32: w = mk("hydroncheat",2,1);    33: w = mk("unicoilcheat",2,1);
            34: w = mk("vegacheat",2,1);      35: w = mk("ring1cheat",2,1);
            36: w = mk("ring-1cheat",2,1);    37: w = mk("rihnocheat",2,1);
            38: w = mk("rihno client",2,1);   39: w = mk("novaclient",2,1);
            40: w = mk("grimclient",2,1);     41: w = mk("prestigeclient",2,1);
            42: w = mk("1337cheat",2,1);      43: w = mk("hydrogencheat",2,1);
            44: w = mk("unicorecheat",2,1);   45: w = mk("qualaclient",2,1);
            46: w = mk("skriptcheat",2,1);    47: w = mk("0xcheats",2,1);
            48: w = mk("venacycheat",2,1);    49: w = mk("bebettercheat",2,1);
            50: w = mk("binarycheat",2,1);    51: w = mk("hxcheats",2,1);
            52: w = mk("bypass.fun",2,1);
            53: w = mk("hdplayercheat",3,1);  54: w = mk("hddplayer",3,1);
            55: w = mk("hdd player",3,1);     56: w = mk("externalcheat",3,1);
            57: w = mk("external cheat",3,1); 58: w = mk("externalmem",3,1);
            59: w = mk("external mem",3,1);
            60: w = mk("bstkvmm",4,1);        61: w = mk("bst kvmm",4,1);
            62: w = mk("kdmapper",4,1);       63: w = mk("kdu.exe",4,1);
            64: w = mk("rawdriver",4,1);      65: w = mk("kernelbypass",4,1);
            66: w = mk("kernel bypass",4,1);  67: w = mk("blackbone",4,1);
            68: w = mk("turla",4,1);          69: w = mk("xenos64",4,0);
            70: w = mk("drivermap",4,0);
            71: w = mk("pcileech",5,1);       72: w = mk("pcie leech",5,1);
            73: w = mk("dma cheat",5,1);      74: w = mk("fpgacheat",5,1);
            75: w = mk("spoofedfirmware",5,1);
            76: w = mk("spoofed firmware",5,1);
            77: w = mk("kmboxnet",5,1);       78: w = mk("kmbox net",5,1);
            79: w = mk("extremeinject",6,1);  80: w = mk("extreme inject",6,1);
            81: w = mk("injector.exe",6,1);   82: w = mk("manualmap",6,1);
            83: w = mk("manual map",6,1);     84: w = mk("galib",6,1);
            85: w = mk("ga lib",6,1);         86: w = mk("gvaclient",6,1);
            87: w = mk("gva client",6,1);     88: w = mk("gva mem",6,1);
            89: w = mk("gva.mem",6,1);        90: w = mk("hiddenxcheat",6,1);
            91: w = mk("hiddenx cheat",6,1);  92: w = mk("garv",6,1);
            93: w = mk("garv cheat",6,1);
            94: w = mk("memread",7,0);        95: w = mk("mem read",7,0);
            96: w = mk("readmem",7,0);        97: w = mk("vmread",7,0);
            98: w = mk("vm read ex",7,0);
            99: w = mk("writeprocessmemory hook",7,0);
            100: w = mk("ntreadprocess",7,0);
            101: w = mk("adb.exe",8,1);       102: w = mk("adb cheat",8,1);
            103: w = mk("bluestackshack",8,1);
            104: w = mk("bluestacks hack",8,1);
            105: w = mk("hwid spoofer",9,1);  106: w = mk("hwid-spoofer",9,1);
            107: w = mk("hwidspoofer",9,1);   108: w = mk("serialspoof",9,1);
            109: w = mk("serial spoof",9,1);  110: w = mk("diskspoofer",9,1);
            111: w = mk("disk spoofer",9,1);  112: w = mk("macspoofer",9,0);
            113: w = mk("mac spoofer",9,0);   114: w = mk("banbypass",9,1);
            115: w = mk("ban bypass",9,1);
            116: w = mk("freshbypass",10,1);  117: w = mk("fresh bypass",10,1);
            118: w = mk("unknownbypass",10,1);
            119: w = mk("unknown bypass",10,1);
            120: w = mk("eventlogbypass",10,1);
            121: w = mk("eventlog bypass",10,1);
            122: w = mk("vhd bypass",10,1);
            123: w = mk("virtualdiskbypass",10,1);
            124: w = mk("journalbypass",10,1);
            125: w = mk("journal bypass",10,1);
            126: w = mk("taskschedbypass",10,0);
            127: w = mk("prefetchbypass",10,0);
            128: w = mk("mousescript",11,0);  129: w = mk("mouse script",11,0);
            130: w = mk("mousemacro",11,0);   131: w = mk("mouse macro",11,0);
            132: w = mk("onboard macro",11,0);
            133: w = mk("onboardmemory",11,0);
            134: w = mk("recoilscript",11,0); 135: w = mk("recoil script",11,0);
            136: w = mk("norecoilscript",11,0);
            137: w = mk("rapidfire",11,0);    138: w = mk("rapid fire",11,0);
            139: w = mk("rpfcheat",12,1);     140: w = mk("rpf cheat",12,1);
            141: w = mk("luacheat",12,1);     142: w = mk("lua cheat",12,1);
            143: w = mk("luainjector",12,1);  144: w = mk("lua injector",12,1);
            default: w = '0;
        endcase
        return w;
    endfunction

    // one window position handed from cell to cell
    typedef struct packed {
        logic       vld;
        logic [7:0] ch;
    } win_tap_t;

    // per-byte control broadcast to the keyword cells
    typedef struct packed {
        logic shift;    // printable byte enters the window
        logic fresh;    // new source: earlier hits gone before this byte
        logic clear;    // run closed on this byte: forget all hits
    } cell_ctl_t;

endpackage
`default_nettype wire

/* src/prkm_win_cell.sv */
// One stage of the lowercased byte window, passing its byte to the next stage
`default_nettype none
module prkm_win_cell
    import prkm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic [7:0] din,
    output logic      [7:0] dout
);
    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;
endmodule
`default_nettype wire

/* src/prkm_kw_cell.sv */
// Keyword cell: compares one ROM keyword against the window and holds its first hit
`default_nettype none
module prkm_kw_cell
    import prkm_pkg::*;
#(
    parameter int KW_IDX      = 0,
    parameter int MAX_KW_LEN  = MaxKeywordLenDefault,
    parameter int CNT_W       = 19,
    parameter int OFF_W       = 18
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctl_t             ctl,
    input  wire logic [MAX_KW_LEN*8-1:0] win,      // newest byte at [7:0]
    input  wire logic [CNT_W-1:0]      cnt_next,   // run count including this byte
    output logic                       hit_now,    // hit in the run up to this byte
    output logic      [OFF_W-1:0]      off_now     // first-hit offset seen with hit_now
);
    localparam rom_word_t Word = word_rom(KW_IDX);
    localparam int        Len  = int'(Word.len);
    localparam bit        Usable = (Len > 0) && (Len <= MAX_KW_LEN);

    logic             hit_reg;
    logic [OFF_W-1:0] off_reg;
    logic             match;
    logic             live;     // stored hit still belongs to the open run
    logic             new_hit;

    // window position Len-1-j must equal keyword character j
    always_comb
    begin
        match = Usable && (cnt_next >= CNT_W'(Len));
        for (int j = 0; j < MAX_KW_LEN; j++)
        begin
            if (j < Len && j < SlotChars)
            begin
                if (win[(Len-1-j)*8 +: 8] != Word.text[j*8 +: 8])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    assign live    = hit_reg && !ctl.fresh;
    assign new_hit = ctl.shift && match && !live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= live || (ctl.shift && match);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && new_hit)
        begin
            off_reg <= OFF_W'(cnt_next - CNT_W'(Len));
        end
    end

    assign hit_now = live || (ctl.shift && match);
    assign off_now = live ? off_reg : OFF_W'(cnt_next - CNT_W'(Len));
endmodule
`default_nettype wire

/* src/printable_run_keyword_matcher_top.sv */
// Top level: printable-run keyword matcher built from a window chain and keyword cells
//
//  Channel   Direction  Handshake          Payload
//  in        input      in_valid/in_ready  byte_value, chunk_end, source_start
//  out       output     out_valid/out_ready keyword_index .. run_length
//  cfg       input      cfg_we             cfg_index, cfg_wdata
//
// One byte per cycle unless stalled. The window and keyword cells update at the byte's
// edge; a qualifying closing byte leaves a report in a two-entry output buffer.
// Bytes are taken while the buffer has room, so the input stalls only when both entries wait.
// Reset clears run count, hits, detection count and window; no clearing pass.
// The priority pick over the hit vector is one combinational encoder.
`default_nettype none
module printable_run_keyword_matcher_top
    import prkm_pkg::*;
#(
    parameter int NUM_KEYWORDS    = NumKeywordsDefault,
    parameter int MAX_KEYWORD_LEN = MaxKeywordLenDefault,
    parameter int CHUNK_BYTES     = ChunkBytesDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        chunk_end,
    input  wire logic        source_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       keyword_index,
    output logic [3:0]       category_code,
    output logic             is_critical,
    output logic [17:0]      match_offset,
    output logic [18:0]      run_length,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    localparam int CntW  = $clog2(CHUNK_BYTES + 1);
    localparam int OffW  = $clog2(CHUNK_BYTES);
    localparam int Words = (RomWords < NUM_KEYWORDS) ? RomWords : NUM_KEYWORDS;

    typedef struct packed {
        logic [7:0]  kidx;
        logic [3:0]  cat;
        logic        crit;
        logic [17:0] off;
        logic [18:0] len;
    } report_t;

    // configuration registers
    logic [4:0] min_run_reg;
    logic [7:0] max_det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg <= MinRunReset;
            max_det_reg <= MaxDetReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegMinRun: min_run_reg <= cfg_wdata[4:0];
                RegMaxDet: max_det_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input decode
    logic       take;
    logic       printable;
    logic [7:0] lower;
    assign take      = in_valid && in_ready;
    assign printable = (byte_value >= TextLo) && (byte_value <= TextHi);
    assign lower     = (byte_value >= 8'h41 && byte_value <= 8'h5A) ?
                       (byte_value + 8'h20) : byte_value;

    // run state
    logic [CntW-1:0] cnt_reg, cnt_base, cnt_next;
    logic [7:0]      det_reg, det_base;
    assign cnt_base = source_start ? '0 : cnt_reg;
    assign det_base = source_start ? '0 : det_reg;
    assign cnt_next = (cnt_base < CntW'(CHUNK_BYTES)) ? cnt_base + 1'b1 : cnt_base;

    // window chain
    logic [MAX_KEYWORD_LEN*8-1:0] win;      // after shift, newest at [7:0]
    logic [7:0] tap [MAX_KEYWORD_LEN];
    logic       win_shift;
    assign win_shift = take && printable;

    genvar g;
    generate
        for (g = 0; g < MAX_KEYWORD_LEN; g++)
        begin : g_win
            if (g == 0)
            begin : g_head
                prkm_win_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(win_shift),
                                      .din(lower), .dout(tap[g]));
                assign win[7:0] = lower;
            end
            else
            begin : g_body
                prkm_win_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(win_shift),
                                      .din(tap[g-1]), .dout(tap[g]));
                assign win[g*8 +: 8] = tap[g-1];
            end
        end
    endgenerate

    // closing conditions
    logic close_np, close_ce, closing;
    logic [CntW-1:0] close_cnt;
    assign close_np  = !printable && (cnt_base != '0);
    assign close_ce  = chunk_end && (printable ? 1'b1 : 1'b0) ;
    assign closing   = take && (close_np || close_ce);
    assign close_cnt = printable ? cnt_next : cnt_base;

    // keyword cells; hits seen by the cells include this byte's match via a bypass
    logic [Words-1:0] hit_now;
    logic [OffW-1:0]  off_now [Words];

    cell_ctl_t cctl;
    assign cctl.shift = win_shift;
    assign cctl.fresh = take && source_start;
    assign cctl.clear = closing;

    generate
        for (g = 0; g < Words; g++)
        begin : g_kw
            prkm_kw_cell #(
                .KW_IDX(g), .MAX_KW_LEN(MAX_KEYWORD_LEN), .CNT_W(CntW), .OFF_W(OffW)
            ) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(cctl), .win(win),
                .cnt_next(cnt_next), .hit_now(hit_now[g]), .off_now(off_now[g])
            );
        end
    endgenerate

    // priority pick of the lowest hit keyword
    logic            any_hit;
    logic [7:0]      pick;
    logic [OffW-1:0] pick_off;
    always_comb
    begin
        any_hit  = 1'b0;
        pick     = '0;
        pick_off = '0;
        for (int k = Words - 1; k >= 0; k--)
        begin
            if (hit_now[k])
            begin
                any_hit  = 1'b1;
                pick     = 8'(k);
                pick_off = off_now[k];
            end
        end
    end

    logic      report;
    report_t   rep;
    rom_word_t pick_word;
    always_comb
    begin
        pick_word = word_rom(int'(pick));
        rep       = '0;
        rep.kidx  = pick;
        rep.cat   = pick_word.cat;
        rep.crit  = pick_word.crit;
        rep.off   = 18'(pick_off);
        rep.len   = 19'(close_cnt);
    end
    assign report = closing && any_hit && (close_cnt >= CntW'(min_run_reg))
                    && (det_base < max_det_reg);

    // run and detection counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            det_reg <= '0;
        end
        else if (take)
        begin
            cnt_reg <= closing ? '0 : (printable ? cnt_next : cnt_base);
            det_reg <= report ? det_base + 1'b1 : det_base;
        end
    end

    // two-entry output buffer
    report_t   buf_reg [2];
    logic [1:0] fill_reg;
    logic       rd_reg, wr_reg;
    logic       pop, push;
    assign pop      = out_valid && out_ready;
    assign push     = take && report;
    assign in_ready = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= rep;
        end
    end

    assign keyword_index = buf_reg[rd_reg].kidx;
    assign category_code = buf_reg[rd_reg].cat;
    assign is_critical   = buf_reg[rd_reg].crit;
    assign match_offset  = buf_reg[rd_reg].off;
    assign run_length    = buf_reg[rd_reg].len;
endmodule
`default_nettype wire
